>>> sv/rbm_pkg.sv
// rbm_pkg: types and constants shared by the blend/mix pipeline.
// No dependencies; imported by rbm_blend, rbm_mix and rgb_blend_mode_alpha_mix.
`timescale 1ns / 1ps

package rbm_pkg;

  localparam int CHAN_W     = 8;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = 2 * CHAN_W;
  // a*c + (100-a)*b never exceeds 25500
  localparam int SUM_W      = 15;
  localparam int RECIP_W    = 13;
  // floor(x/100) == (x*5243) >> 19 for every x below 43690
  localparam int RECIP_SHIFT = 19;
  localparam int QPROD_W    = SUM_W + RECIP_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CHAN_W-1:0]  CHAN_MAX      = 8'd255;
  localparam logic [CHAN_W-1:0]  OVERLAY_SPLIT = 8'd128;
  localparam logic [PCT_W-1:0]   PERCENT_FULL  = 7'd100;
  localparam logic [RECIP_W-1:0] RECIP_100     = 13'd5243;
  localparam logic [SUM_W-1:0]   SUM_MAX       = 15'd25500;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 1'b1;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_DARKEN   = 3'd4
  } blend_mode_t;

  // how stage 2 forms the blended channel: from the stage-1 product, or by min / pass
  typedef enum logic [2:0] {
    K_PASS,
    K_MIN,
    K_PROD8,
    K_INV8,
    K_PROD7,
    K_INV7
  } ckind_t;

  typedef struct packed {
    logic [CHAN_W-1:0] fg_red;
    logic [CHAN_W-1:0] fg_green;
    logic [CHAN_W-1:0] fg_blue;
    logic [CHAN_W-1:0] bg_red;
    logic [CHAN_W-1:0] bg_green;
    logic [CHAN_W-1:0] bg_blue;
  } rbm_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } rbm_out_t;

endpackage

>>> sv/rbm_blend.sv
// rbm_blend: two-stage blend-mode unit for one channel (product, then select).
// Depends on rbm_pkg.
`timescale 1ns / 1ps

module rbm_blend (
  input  logic                       clk,
  input  logic [rbm_pkg::CHAN_W-1:0] f,
  input  logic [rbm_pkg::CHAN_W-1:0] b,
  input  rbm_pkg::blend_mode_t       mode,
  output logic [rbm_pkg::CHAN_W-1:0] c,
  output logic [rbm_pkg::CHAN_W-1:0] b_out
);
  import rbm_pkg::*;

  ckind_t              kind_nxt;
  logic                use_inv;
  logic [CHAN_W-1:0]   mul_a;
  logic [CHAN_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod_nxt;

  ckind_t              kind_r;
  logic [PROD_W-1:0]   prod_r;
  logic [CHAN_W-1:0]   f_r;
  logic [CHAN_W-1:0]   b1_r;

  logic [CHAN_W-1:0]   c_nxt;
  logic [CHAN_W-1:0]   c_r;
  logic [CHAN_W-1:0]   b2_r;

  // stage 1: decode mode, one 8x8 multiply
  always_comb begin
    kind_nxt = K_PASS;
    use_inv  = 1'b0;
    case (mode)
      MODE_MULTIPLY: begin
        kind_nxt = K_PROD8;
      end
      MODE_SCREEN: begin
        kind_nxt = K_INV8;
        use_inv  = 1'b1;
      end
      MODE_OVERLAY: begin
        if (f < OVERLAY_SPLIT) begin
          kind_nxt = K_PROD7;
        end else begin
          kind_nxt = K_INV7;
          use_inv  = 1'b1;
        end
      end
      MODE_DARKEN: begin
        kind_nxt = K_MIN;
      end
      default: begin
        kind_nxt = K_PASS;
      end
    endcase
    mul_a    = use_inv ? (CHAN_MAX - f) : f;
    mul_b    = use_inv ? (CHAN_MAX - b) : b;
    prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    prod_r <= prod_nxt;
    f_r    <= f;
    b1_r   <= b;
  end

  // stage 2: shift / invert / min
  always_comb begin
    case (kind_r)
      K_MIN:   c_nxt = (f_r < b1_r) ? f_r : b1_r;
      K_PROD8: c_nxt = prod_r[PROD_W-1:CHAN_W];
      K_INV8:  c_nxt = CHAN_MAX - prod_r[PROD_W-1:CHAN_W];
      K_PROD7: c_nxt = prod_r[PROD_W-2:CHAN_W-1];
      K_INV7:  c_nxt = CHAN_MAX - prod_r[PROD_W-2:CHAN_W-1];
      default: c_nxt = f_r;
    endcase
  end

  always_ff @(posedge clk) begin
    c_r  <= c_nxt;
    b2_r <= b1_r;
  end

  assign c     = c_r;
  assign b_out = b2_r;

endmodule

>>> sv/rbm_mix.sv
// rbm_mix: two-stage opacity mix for one channel: weighted sum, then /100
// by reciprocal multiply. Depends on rbm_pkg.
`timescale 1ns / 1ps

module rbm_mix (
  input  logic                       clk,
  input  logic [rbm_pkg::PCT_W-1:0]  alpha,
  input  logic [rbm_pkg::CHAN_W-1:0] c,
  input  logic [rbm_pkg::CHAN_W-1:0] b,
  output logic [rbm_pkg::CHAN_W-1:0] q
);
  import rbm_pkg::*;

  logic [PCT_W-1:0]   beta;
  logic [SUM_W-1:0]   sum_nxt;
  logic [SUM_W-1:0]   sum_r;
  logic [QPROD_W-1:0] qprod;
  logic [CHAN_W-1:0]  q_nxt;
  logic [CHAN_W-1:0]  q_r;

  // stage 3: a*c + (100-a)*b, alpha already clamped to 0..100
  always_comb begin
    beta    = PERCENT_FULL - alpha;
    sum_nxt = SUM_W'(alpha) * SUM_W'(c) + SUM_W'(beta) * SUM_W'(b);
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // stage 4: floor(sum/100)
  always_comb begin
    qprod = QPROD_W'(sum_r) * QPROD_W'(RECIP_100);
    q_nxt = qprod[RECIP_SHIFT +: CHAN_W];
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> sv/rgb_blend_mode_alpha_mix.sv
// rgb_blend_mode_alpha_mix: top level; config registers, valid chain and
// three channel lanes of rbm_blend + rbm_mix. Depends on rbm_pkg.
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ---------------------------
//   input     start, busy, in_data                beat taken when start & !busy
//   result    out_valid, out_data                 one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_wdata        write when cfg_we high
//
// One pixel per clock: multiply, mode select, weighted sum and reciprocal
// divide by 100, each its own register stage.
// busy never rises; the pipeline is always free to take a beat.
// Synchronous active-low reset clears the valid chain and sets blend_mode
// to normal and opacity to 100. Data registers are not reset.
`timescale 1ns / 1ps

module rgb_blend_mode_alpha_mix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  rbm_pkg::rbm_in_t               in_data,
  output logic                           out_valid,
  output rbm_pkg::rbm_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rbm_pkg::*;

  localparam int NSTAGE = 4;

  logic [2:0]        mode_r;
  logic [PCT_W-1:0]  opacity_r;
  logic [PCT_W-1:0]  alpha;
  blend_mode_t       mode;

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] valid_nxt;

  logic [CHAN_W-1:0] c_red, c_green, c_blue;
  logic [CHAN_W-1:0] bd_red, bd_green, bd_blue;
  logic [CHAN_W-1:0] q_red, q_green, q_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 3'(MODE_NORMAL);
      opacity_r <= PERCENT_FULL;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLEND_MODE: mode_r    <= cfg_wdata[2:0];
        REG_OPACITY:    opacity_r <= cfg_wdata[PCT_W-1:0];
        default:        ;
      endcase
    end
  end

  assign mode  = blend_mode_t'(mode_r);
  assign alpha = (opacity_r > PERCENT_FULL) ? PERCENT_FULL : opacity_r;
  assign busy  = 1'b0;

  assign valid_nxt = {valid_r[NSTAGE-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  rbm_blend u_blend_red (
    .clk(clk), .f(in_data.fg_red), .b(in_data.bg_red), .mode(mode),
    .c(c_red), .b_out(bd_red)
  );
  rbm_blend u_blend_green (
    .clk(clk), .f(in_data.fg_green), .b(in_data.bg_green), .mode(mode),
    .c(c_green), .b_out(bd_green)
  );
  rbm_blend u_blend_blue (
    .clk(clk), .f(in_data.fg_blue), .b(in_data.bg_blue), .mode(mode),
    .c(c_blue), .b_out(bd_blue)
  );

  rbm_mix u_mix_red (
    .clk(clk), .alpha(alpha), .c(c_red), .b(bd_red), .q(q_red)
  );
  rbm_mix u_mix_green (
    .clk(clk), .alpha(alpha), .c(c_green), .b(bd_green), .q(q_green)
  );
  rbm_mix u_mix_blue (
    .clk(clk), .alpha(alpha), .c(c_blue), .b(bd_blue), .q(q_blue)
  );

  assign out_valid          = valid_r[NSTAGE-1];
  assign out_data.out_red   = q_red;
  assign out_data.out_green = q_green;
  assign out_data.out_blue  = q_blue;

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> valid_r[0])
    else $error("accepted beat did not enter stage 1");

  a_chain_moves: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] |=> valid_r[1])
    else $error("valid lost between stage 1 and 2");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[NSTAGE-2] |=> out_valid)
    else $error("valid lost before the result strobe");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r[NSTAGE-2] |=> !out_valid)
    else $error("result strobe without a beat behind it");
`endif

endmodule

>>> sim/rgb_blend_mode_alpha_mix_tb.sv
// Self-checking bench for rgb_blend_mode_alpha_mix: a directed table, then random pixel
// phases, each under its own blend mode; most phases also write a new opacity. Every pixel beat is scored.
// Depends on rbm_pkg (sv/rbm_pkg.sv) and the block itself.
`timescale 1ns / 1ps

module rgb_blend_mode_alpha_mix_tb;
  import rbm_pkg::*;

  localparam int unsigned MULT_SHIFT     = 8;
  localparam int unsigned OVERLAY_SHIFT  = 7;
  localparam logic [2:0]  MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0]  MODE_SPARE_HI  = 3'd7;
  localparam int          PIPE_LATENCY   = 4;
  localparam int          NUM_PHASES     = 37;
  localparam int          PHASE_PIXELS   = 50;
  localparam int          MAX_GAP        = 13;
  localparam int          NUM_ROWS       = 20;

  // one directed beat: optional register setting, the pixel, and an optional hand-typed answer
  typedef struct packed {
    logic                  set_regs;
    logic [CFG_DATA_W-1:0] mode_wd;
    logic [CFG_DATA_W-1:0] opacity_wd;
    rbm_in_t               pixel;
    logic                  typed;
    rbm_out_t              typed_out;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  rbm_in_t               in_data;
  logic                  out_valid;
  rbm_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // bench copy of the two registers
  logic [2:0]       mode_cfg;
  logic [PCT_W-1:0] opacity_cfg;

  logic     typed_chk;
  rbm_out_t typed_px;
  rbm_out_t pending_pixels[$];
  int       mismatches;

  dir_row_t dir_rows [0:NUM_ROWS-1] = '{
    // reset setting: normal, full opacity
    '{1'b0, 7'(MODE_NORMAL), 7'd100, 48'h123456_abcdef, 1'b1, 24'h123456},
    '{1'b0, 7'(MODE_NORMAL), 7'd100, 48'hffffff_000000, 1'b1, 24'hffffff},
    // zero opacity passes the background through
    '{1'b1, 7'(MODE_NORMAL), 7'd0,   48'hffffff_000000, 1'b1, 24'h000000},
    '{1'b0, 7'(MODE_NORMAL), 7'd0,   48'h000000_abcdef, 1'b1, 24'habcdef},
    '{1'b1, 7'(MODE_NORMAL), 7'd50,  48'hffffff_000000, 1'b1, 24'h7f7f7f},
    '{1'b1, 7'(MODE_MULTIPLY), 7'd100, 48'hffffff_ffffff, 1'b1, 24'hfefefe},
    '{1'b0, 7'(MODE_MULTIPLY), 7'd100, 48'h00ff80_ff0080, 1'b1, 24'h000040},
    '{1'b1, 7'(MODE_SCREEN), 7'd100, 48'h000000_000000, 1'b1, 24'h010101},
    '{1'b0, 7'(MODE_SCREEN), 7'd100, 48'hff0000_00ff00, 1'b1, 24'hffff01},
    // overlay on both sides of the split: 127 and 128
    '{1'b1, 7'(MODE_OVERLAY), 7'd100, 48'h7f8000_ff00ff, 1'b1, 24'hfd0200},
    '{1'b0, 7'(MODE_OVERLAY), 7'd100, 48'h3c9ae1_5a7f20, 1'b0, 24'h0},
    '{1'b1, 7'(MODE_DARKEN), 7'd100, 48'h10ff80_200080, 1'b1, 24'h100080},
    // spare mode codes act as normal; high data bits of the mode write are dropped
    '{1'b1, {4'b1010, MODE_SPARE_LO}, 7'd100, 48'h123456_654321, 1'b1, 24'h123456},
    '{1'b1, {4'b0000, MODE_SPARE_HI}, 7'd100, 48'habcdef_000000, 1'b1, 24'habcdef},
    // opacity above 100 saturates
    '{1'b1, 7'(MODE_NORMAL), 7'd127, 48'h123456_000000, 1'b1, 24'h123456},
    '{1'b1, 7'(MODE_NORMAL), 7'd101, 48'hffffff_000000, 1'b1, 24'hffffff},
    '{1'b1, {4'b1111, MODE_OVERLAY}, 7'd37, 48'h80ff7f_40c0ff, 1'b0, 24'h0},
    '{1'b1, 7'(MODE_SCREEN), 7'd73, 48'h9a3c01_fe11dd, 1'b0, 24'h0},
    '{1'b1, 7'(MODE_MULTIPLY), 7'd1, 48'h77c3e8_8d1299, 1'b0, 24'h0},
    '{1'b1, 7'(MODE_DARKEN), 7'd99, 48'h00ff55_ff0066, 1'b0, 24'h0}
  };

  rgb_blend_mode_alpha_mix u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] f, logic [CHAN_W-1:0] b);
    int unsigned fi = f;
    int unsigned bi = b;
    int unsigned cmax = CHAN_MAX;
    case (mode_cfg)
      MODE_MULTIPLY: return CHAN_W'((fi * bi) >> MULT_SHIFT);
      MODE_SCREEN:   return CHAN_W'(cmax - (((cmax - fi) * (cmax - bi)) >> MULT_SHIFT));
      MODE_OVERLAY: begin
        if (fi < OVERLAY_SPLIT) return CHAN_W'((fi * bi) >> OVERLAY_SHIFT);
        return CHAN_W'(cmax - (((cmax - fi) * (cmax - bi)) >> OVERLAY_SHIFT));
      end
      MODE_DARKEN:   return (f < b) ? f : b;
      default:       return f;
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] f, logic [CHAN_W-1:0] b);
    int unsigned full = PERCENT_FULL;
    int unsigned a;
    int unsigned sum;
    a = (opacity_cfg > PERCENT_FULL) ? full : opacity_cfg;
    sum = a * blend_chan(f, b) + (full - a) * b;
    return CHAN_W'(sum / full);
  endfunction

  function automatic rbm_out_t blend_mix_pixel(rbm_in_t px);
    rbm_out_t r;
    r.out_red   = mix_chan(px.fg_red, px.bg_red);
    r.out_green = mix_chan(px.fg_green, px.bg_green);
    r.out_blue  = mix_chan(px.fg_blue, px.bg_blue);
    return r;
  endfunction

  // channel values weighted toward the edges and the overlay split
  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CHAN_MAX;
      2:       return CHAN_W'($urandom_range(OVERLAY_SPLIT - 1, OVERLAY_SPLIT));
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // accept and score at the rising edge
  always @(posedge clk) begin : scoreboard
    rbm_out_t want;
    rbm_out_t exp_px;
    if (rst_n && start && !busy) begin
      exp_px = typed_chk ? typed_px : blend_mix_pixel(in_data);
      pending_pixels = {pending_pixels, exp_px};
    end
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("result beat %h with nothing pending", out_data);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.out_red !== want.out_red) begin
          $error("out_red: expected %0d, got %0d", want.out_red, out_data.out_red);
          mismatches++;
        end
        if (out_data.out_green !== want.out_green) begin
          $error("out_green: expected %0d, got %0d", want.out_green, out_data.out_green);
          mismatches++;
        end
        if (out_data.out_blue !== want.out_blue) begin
          $error("out_blue: expected %0d, got %0d", want.out_blue, out_data.out_blue);
          mismatches++;
        end
      end
    end
  end

  task automatic send_pixel(input rbm_in_t px, input int gap, input logic typed,
                            input rbm_out_t typed_out);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start     <= 1'b1;
    in_data   <= px;
    typed_chk <= typed;
    typed_px  <= typed_out;
    do @(posedge clk); while (busy);
  endtask

  // stop sending, let the pipe empty
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_regs(input logic do_mode, input logic [CFG_DATA_W-1:0] mode_wd,
                            input logic do_opacity, input logic [CFG_DATA_W-1:0] opacity_wd);
    if (do_mode) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_BLEND_MODE;
      cfg_wdata <= mode_wd;
      mode_cfg = mode_wd[2:0];
    end
    if (do_opacity) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_OPACITY;
      cfg_wdata <= opacity_wd;
      opacity_cfg = opacity_wd;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    rbm_in_t          px;
    logic [2:0]       mode_pick;
    logic [PCT_W-1:0] opacity_pick;
    logic             burst;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    typed_chk   = 1'b0;
    typed_px    = '0;
    mismatches  = 0;
    mode_cfg    = MODE_NORMAL;
    opacity_cfg = PERCENT_FULL;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (dir_rows[i].set_regs) begin
        drain_pipe();
        write_regs(1'b1, dir_rows[i].mode_wd, 1'b1, dir_rows[i].opacity_wd);
      end
      send_pixel(dir_rows[i].pixel, $urandom_range(0, 2), dir_rows[i].typed,
                 dir_rows[i].typed_out);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_pipe();
      mode_pick = 3'(ph);
      case ($urandom_range(0, 9))
        0:       opacity_pick = '0;
        1:       opacity_pick = PERCENT_FULL;
        2:       opacity_pick = PCT_W'($urandom_range(PERCENT_FULL + 1, 127));
        default: opacity_pick = PCT_W'($urandom_range(0, PERCENT_FULL));
      endcase
      // junk in the mode write's upper bits now and then
      write_regs(1'b1, {($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'b0, mode_pick},
                 $urandom_range(0, 3) != 0, opacity_pick);
      burst = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        px.fg_red   = rand_chan();
        px.fg_green = rand_chan();
        px.fg_blue  = rand_chan();
        px.bg_red   = rand_chan();
        px.bg_green = rand_chan();
        px.bg_blue  = rand_chan();
        send_pixel(px, burst ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
      end
    end

    drain_pipe();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
